/* design/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg: shared types and constants of the stack machine executor
// Instruction header codes, primitive codes, status codes and the divider
// request bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

	localparam int WORD_W   = 32;
	localparam int OP_W     = 2;
	localparam int VALUE_W  = 30;
	localparam int DEPTH_W  = 11;
	localparam int STATUS_W = 3;

	// instruction headers
	localparam logic [OP_W-1:0] OP_PUSH_POS = 2'd0;
	localparam logic [OP_W-1:0] OP_PRIM     = 2'd1;
	localparam logic [OP_W-1:0] OP_PUSH_NEG = 2'd2;
	localparam logic [OP_W-1:0] OP_PRIM_ALT = 2'd3;

	// primitive codes
	localparam logic [VALUE_W-1:0] PRIM_HALT = 30'd0;
	localparam logic [VALUE_W-1:0] PRIM_ADD  = 30'd1;
	localparam logic [VALUE_W-1:0] PRIM_SUB  = 30'd2;
	localparam logic [VALUE_W-1:0] PRIM_MUL  = 30'd3;
	localparam logic [VALUE_W-1:0] PRIM_DIV  = 30'd4;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] ST_IGNORED   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd4;

	// request to the iterative divider
	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] dividend;
		logic [WORD_W-1:0] divisor;
	} div_req_t;

endpackage

`default_nettype wire

/* design/smx_in_if.sv */
// ----------------------------------------------------------------------------
// smx_in_if: instruction channel
// Valid/ready channel carrying one instruction word: header and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smx_in_if;
	logic                        valid;
	logic                        ready;
	logic [smx_pkg::OP_W-1:0]    op;
	logic [smx_pkg::VALUE_W-1:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

`default_nettype wire

/* design/smx_out_if.sv */
// ----------------------------------------------------------------------------
// smx_out_if: result channel
// Valid/ready channel carrying the machine state after one instruction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smx_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [smx_pkg::WORD_W-1:0]   top_of_stack;
	logic [smx_pkg::DEPTH_W-1:0]         stack_depth;
	logic                                halted;
	logic [smx_pkg::STATUS_W-1:0]        status;

	modport source (output valid, output top_of_stack, output stack_depth,
		output halted, output status, input ready);
	modport sink   (input valid, input top_of_stack, input stack_depth,
		input halted, input status, output ready);
endinterface

`default_nettype wire

/* design/smx_ram.sv */
// ----------------------------------------------------------------------------
// smx_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

/* design/smx_div.sv */
// ----------------------------------------------------------------------------
// smx_div: iterative signed divider
// Restoring division on magnitudes, one quotient bit per cycle, truncating
// toward zero. Quotient valid while done is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smx_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire smx_pkg::div_req_t             req,
	output logic                               done,
	output logic [smx_pkg::WORD_W-1:0]         quotient
);

	localparam int W  = smx_pkg::WORD_W;
	localparam int SW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [SW-1:0] step_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  dvs_q;
	logic          neg_q;

	logic [W:0]    shifted;
	logic [W+1:0]  diff;
	logic [W-1:0]  mag_a;
	logic [W-1:0]  mag_b;

	// operand magnitudes and one trial subtraction
	always_comb begin
		mag_a   = req.dividend[W-1] ? (W'(0) - req.dividend) : req.dividend;
		mag_b   = req.divisor[W-1] ? (W'(0) - req.divisor) : req.divisor;
		shifted = {rem_q, quo_q[W-1]};
		diff    = {1'b0, shifted} - {2'b00, dvs_q};
	end

	// control: start, count steps, flag completion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + SW'(1);
			if (step_q == SW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath: load magnitudes, shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			dvs_q <= mag_b;
			neg_q <= req.dividend[W-1] ^ req.divisor[W-1];
		end else if (busy_q) begin
			if (!diff[W+1]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

/* design/stack_machine_executor.sv */
// ----------------------------------------------------------------------------
// stack_machine_executor: stack machine arithmetic interpreter
// Runs one push or primitive instruction per word and reports the stack.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one instruction word (op header, 30-bit value); rsp returns
//   one word per instruction: top of stack, depth, halted flag and status.
//   cmd.ready is high only while the sequencer is idle; one word is taken
//   and worked on alone.
//   Pushes, halts, unknown codes, ignored words, overflow and underflow go
//   from decode straight to the done state; add, sub, mul and divide by zero
//   pass through the execute state first, which takes the left operand from
//   the registered read of the stack RAM, and divide then waits in the divide
//   state for the 32 steps of the one-bit-per-cycle divider.
//   The result sits in an output register, so a new word is taken while an
//   earlier result waits; if the receiver stalls longer, the next result is
//   held inside and cmd.ready stays low until it can be handed over.
//   Reset empties the stack and clears the halted flag; the stack RAM is not
//   cleared, as only entries below the depth are ever used.
//   After a halt every word is answered with the ignored status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stack_machine_executor #(
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	smx_in_if.sink     cmd,
	smx_out_if.source  rsp
);

	localparam int W  = smx_pkg::WORD_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_EXEC = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]                     state_q;
	logic [smx_pkg::OP_W-1:0]       op_q;
	logic [smx_pkg::VALUE_W-1:0]    value_q;
	logic [CW-1:0]                  count_q;
	logic                           running_q;
	logic [W-1:0]                   tos_q;
	logic [smx_pkg::STATUS_W-1:0]   status_q;

	logic                           rsp_valid_q;
	logic [W-1:0]                   rsp_tos_q;
	logic [smx_pkg::DEPTH_W-1:0]    rsp_depth_q;
	logic                           rsp_halted_q;
	logic [smx_pkg::STATUS_W-1:0]   rsp_status_q;

	logic                           is_push;
	logic [W-1:0]                   push_val;
	logic [CW-1:0]                  below_top;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [W-1:0]                   ram_wdata;
	logic [W-1:0]                   lhs;
	logic [W-1:0]                   alu_res;
	logic                           div_done;
	logic [W-1:0]                   div_quo;
	smx_pkg::div_req_t              div_req;
	logic                           rsp_free;

	// decode helpers
	always_comb begin
		is_push   = (op_q == smx_pkg::OP_PUSH_POS) || (op_q == smx_pkg::OP_PUSH_NEG);
		push_val  = (op_q == smx_pkg::OP_PUSH_NEG) ? (W'(0) - W'(value_q)) : W'(value_q);
		below_top = count_q - CW'(2);
		rsp_free  = !rsp_valid_q || rsp.ready;
	end

	// add, sub and mul on the two top entries
	always_comb begin
		case (value_q)
			smx_pkg::PRIM_ADD: alu_res = lhs + tos_q;
			smx_pkg::PRIM_SUB: alu_res = lhs - tos_q;
			default:           alu_res = lhs * tos_q;
		endcase
	end

	// stack RAM write port: push at the depth, results over the second entry
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = below_top[AW-1:0];
		ram_wdata = alu_res;
		case (state_q)
			S_DEC: begin
				if (running_q && is_push && (count_q < CW'(STACK_DEPTH))) begin
					ram_we    = 1'b1;
					ram_waddr = count_q[AW-1:0];
					ram_wdata = push_val;
				end
			end
			S_EXEC: begin
				ram_we = (value_q != smx_pkg::PRIM_DIV);
			end
			S_DIV: begin
				ram_we    = div_done;
				ram_wdata = div_quo;
			end
			default: ram_we = 1'b0;
		endcase
	end

	// start the divider once the left operand is read
	always_comb begin
		div_req.start    = (state_q == S_EXEC) && (value_q == smx_pkg::PRIM_DIV)
			&& (tos_q != '0);
		div_req.dividend = lhs;
		div_req.divisor  = tos_q;
	end

	smx_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (below_top[AW-1:0]),
		.rdata (lhs)
	);

	smx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quo)
	);

	// sequencer and machine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			running_q <= 1'b1;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (running_q && is_push) begin
						if (count_q < CW'(STACK_DEPTH)) begin
							count_q <= count_q + CW'(1);
						end
						state_q <= S_DONE;
					end else if (running_q && (value_q == smx_pkg::PRIM_HALT)) begin
						running_q <= 1'b0;
						state_q   <= S_DONE;
					end else if (running_q && (value_q <= smx_pkg::PRIM_DIV)
						&& (count_q >= CW'(2))) begin
						state_q <= S_EXEC;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_EXEC: begin
					if (value_q != smx_pkg::PRIM_DIV) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end else if (tos_q == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// instruction latch, top-of-stack and status
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && cmd.valid) begin
			op_q    <= cmd.op;
			value_q <= cmd.value;
		end
		case (state_q)
			S_DEC: begin
				if (!running_q) begin
					status_q <= smx_pkg::ST_IGNORED;
				end else if (is_push) begin
					if (count_q < CW'(STACK_DEPTH)) begin
						tos_q    <= push_val;
						status_q <= smx_pkg::ST_OK;
					end else begin
						status_q <= smx_pkg::ST_OVERFLOW;
					end
				end else if ((value_q != smx_pkg::PRIM_HALT) && (value_q <= smx_pkg::PRIM_DIV)
					&& (count_q < CW'(2))) begin
					status_q <= smx_pkg::ST_UNDERFLOW;
				end else begin
					status_q <= smx_pkg::ST_OK;
				end
			end
			S_EXEC: begin
				if (value_q != smx_pkg::PRIM_DIV) begin
					tos_q <= alu_res;
				end else if (tos_q == '0) begin
					status_q <= smx_pkg::ST_DIVZERO;
				end
			end
			S_DIV: begin
				if (div_done) begin
					tos_q <= div_quo;
				end
			end
			default: ;
		endcase
	end

	// output register: load when free, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && rsp_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && rsp_free) begin
			rsp_tos_q    <= (count_q == '0) ? '0 : tos_q;
			rsp_depth_q  <= smx_pkg::DEPTH_W'(count_q);
			rsp_halted_q <= !running_q;
			rsp_status_q <= status_q;
		end
	end

	assign cmd.ready        = (state_q == S_IDLE);
	assign rsp.valid        = rsp_valid_q;
	assign rsp.top_of_stack = rsp_tos_q;
	assign rsp.stack_depth  = rsp_depth_q;
	assign rsp.halted       = rsp_halted_q;
	assign rsp.status       = rsp_status_q;

endmodule

`default_nettype wire
